FILE: rtl/multi_queue_front_back_insert_core_defines.svh
// Assertion macros shared by the RTL.
`ifndef MULTI_QUEUE_FRONT_BACK_INSERT_CORE_DEFINES_SVH
`define MULTI_QUEUE_FRONT_BACK_INSERT_CORE_DEFINES_SVH

// Same-cycle implication.
`define MQFB_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("check failed");

// Next-cycle implication.
`define MQFB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("check failed");

`endif

FILE: rtl/mqfb_pkg.sv
package mqfb_pkg;

    localparam int QIDX_W     = 5;
    localparam int IN_ID_W    = 16;
    localparam int FILL_OUT_W = 4;

    localparam logic MODE_ADD  = 1'b0;
    localparam logic MODE_TAKE = 1'b1;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_APPEND,
        OP_PUSH,
        OP_POP
    } t_op;

    typedef struct packed {
        t_op  op;
        logic tail;
    } t_cell_ctl;

    typedef struct packed {
        logic               mode;
        logic [QIDX_W-1:0]  queue_index;
        logic [IN_ID_W-1:0] item_id;
        logic               item_urgent;
    } t_req;

    typedef struct packed {
        logic [1:0]            result_status;
        logic [IN_ID_W-1:0]    taken_id;
        logic                  taken_urgent;
        logic [FILL_OUT_W-1:0] fill_after;
    } t_rsp;

endpackage

FILE: rtl/mqfb_req_if.sv
interface mqfb_req_if
    import mqfb_pkg::*;
;
    logic valid;
    logic ready;
    t_req payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

FILE: rtl/mqfb_rsp_if.sv
interface mqfb_rsp_if
    import mqfb_pkg::*;
;
    logic valid;
    logic ready;
    t_rsp payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

FILE: rtl/mqfb_cell.sv
module mqfb_cell
    import mqfb_pkg::*;
#(
    parameter int ENTRY_W = 17
) (
    input  logic               i_clk,
    input  t_cell_ctl          i_ctl,
    input  logic [ENTRY_W-1:0] i_new,
    input  logic [ENTRY_W-1:0] i_prev,
    input  logic [ENTRY_W-1:0] i_next,
    output logic [ENTRY_W-1:0] o_data
);

    logic [ENTRY_W-1:0] r_data;
    logic [ENTRY_W-1:0] n_data;

    always_comb begin
        n_data = r_data;
        case (i_ctl.op)
            OP_APPEND: begin
                if (i_ctl.tail) begin
                    n_data = i_new;
                end
            end
            OP_PUSH: n_data = i_prev;
            OP_POP:  n_data = i_next;
            default: n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

FILE: rtl/mqfb_row.sv
module mqfb_row
    import mqfb_pkg::*;
#(
    parameter int ROW_IDX     = 0,
    parameter int QUEUE_DEPTH = 8,
    parameter int ID_WIDTH    = 16,
    parameter int FILL_W      = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  t_req                i_req,
    output logic [FILL_W-1:0]   o_fill,
    output logic [ID_WIDTH:0]   o_head
);

    localparam int ENTRY_W = ID_WIDTH + 1;

    logic [FILL_W-1:0]  r_fill;
    logic [FILL_W-1:0]  n_fill;
    logic               w_hit;
    logic               w_full;
    logic               w_empty;
    t_op                w_op;
    logic [63:0]        w_id_ext;
    logic [ENTRY_W-1:0] w_new;
    logic [ENTRY_W-1:0] w_data [QUEUE_DEPTH];

    assign w_hit   = i_fire && (int'(i_req.queue_index) == ROW_IDX);
    assign w_full  = (r_fill == FILL_W'(QUEUE_DEPTH));
    assign w_empty = (r_fill == '0);

    assign w_id_ext = 64'(i_req.item_id);
    assign w_new    = {i_req.item_urgent, w_id_ext[ID_WIDTH-1:0]};

    always_comb begin
        w_op   = OP_HOLD;
        n_fill = r_fill;
        if (w_hit) begin
            if (i_req.mode == MODE_ADD) begin
                if (!w_full) begin
                    w_op   = i_req.item_urgent ? OP_PUSH : OP_APPEND;
                    n_fill = r_fill + FILL_W'(1);
                end
            end else if (!w_empty) begin
                w_op   = OP_POP;
                n_fill = r_fill - FILL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else begin
            r_fill <= n_fill;
        end
    end

    for (genvar p = 0; p < QUEUE_DEPTH; p++) begin : g_cell
        t_cell_ctl          w_ctl;
        logic [ENTRY_W-1:0] w_prev;
        logic [ENTRY_W-1:0] w_next;

        assign w_ctl.op   = w_op;
        assign w_ctl.tail = (r_fill == FILL_W'(p));

        if (p == 0) begin : g_first
            assign w_prev = w_new;
        end else begin : g_mid
            assign w_prev = w_data[p-1];
        end

        if (p == QUEUE_DEPTH - 1) begin : g_last
            assign w_next = '0;
        end else begin : g_inner
            assign w_next = w_data[p+1];
        end

        mqfb_cell #(
            .ENTRY_W(ENTRY_W)
        ) u_cell (
            .i_clk  (i_clk),
            .i_ctl  (w_ctl),
            .i_new  (w_new),
            .i_prev (w_prev),
            .i_next (w_next),
            .o_data (w_data[p])
        );
    end

    assign o_fill = r_fill;
    assign o_head = w_data[0];

endmodule

FILE: rtl/multi_queue_front_back_insert_core.sv
// A result is registered when its request transfers.
// Throughput: one request per cycle unless the response stalls; every
// queue is a row of shift cells updated in parallel on request transfer.
// Reset: synchronous, active low; all fill counts clear to zero and the
// output register empties. Cell contents are not reset.
module multi_queue_front_back_insert_core
    import mqfb_pkg::*;
#(
    parameter int NUM_QUEUES  = 32,
    parameter int QUEUE_DEPTH = 8,
    parameter int ID_WIDTH    = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mqfb_req_if.sink   i_req,
    mqfb_rsp_if.source o_rsp
);

    `include "multi_queue_front_back_insert_core_defines.svh"

    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
    localparam int QSEL_W = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;

    logic              w_fire;
    logic [FILL_W-1:0] w_fill [NUM_QUEUES];
    logic [ID_WIDTH:0] w_head [NUM_QUEUES];
    logic [5:0]        w_qx;
    logic [QSEL_W-1:0] w_qsel;
    logic              w_in_range;
    logic [FILL_W-1:0] w_fill_sel;
    logic [ID_WIDTH:0] w_head_sel;
    logic [63:0]       w_head_id_ext;
    t_rsp              n_rsp;
    t_rsp              r_rsp;
    logic              r_valid;

    assign i_req.ready = !r_valid || o_rsp.ready;
    assign w_fire      = i_req.valid && i_req.ready;

    for (genvar q = 0; q < NUM_QUEUES; q++) begin : g_row
        mqfb_row #(
            .ROW_IDX     (q),
            .QUEUE_DEPTH (QUEUE_DEPTH),
            .ID_WIDTH    (ID_WIDTH),
            .FILL_W      (FILL_W)
        ) u_row (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_fire  (w_fire),
            .i_req   (i_req.payload),
            .o_fill  (w_fill[q]),
            .o_head  (w_head[q])
        );
    end

    assign w_qx       = 6'(i_req.payload.queue_index);
    assign w_qsel     = w_qx[QSEL_W-1:0];
    assign w_in_range = (int'(w_qx) < NUM_QUEUES);
    assign w_fill_sel = w_fill[w_qsel];
    assign w_head_sel = w_head[w_qsel];
    assign w_head_id_ext = 64'(w_head_sel[ID_WIDTH-1:0]);

    always_comb begin
        n_rsp = '0;
        if (!w_in_range) begin
            n_rsp.result_status = (i_req.payload.mode == MODE_ADD) ? ST_FULL : ST_EMPTY;
        end else if (i_req.payload.mode == MODE_ADD) begin
            if (w_fill_sel == FILL_W'(QUEUE_DEPTH)) begin
                n_rsp.result_status = ST_FULL;
                n_rsp.fill_after    = FILL_OUT_W'(w_fill_sel);
            end else begin
                n_rsp.result_status = ST_DONE;
                n_rsp.fill_after    = FILL_OUT_W'(w_fill_sel + FILL_W'(1));
            end
        end else if (w_fill_sel == '0) begin
            n_rsp.result_status = ST_EMPTY;
        end else begin
            n_rsp.result_status = ST_DONE;
            n_rsp.taken_id      = w_head_id_ext[IN_ID_W-1:0];
            n_rsp.taken_urgent  = w_head_sel[ID_WIDTH];
            n_rsp.fill_after    = FILL_OUT_W'(w_fill_sel - FILL_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            if (w_fire) begin
                r_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_rsp.valid   = r_valid;
    assign o_rsp.payload = r_rsp;

    `MQFB_ASSERT_NEXT(a_fire_gives_result, i_clk, i_rst_n, w_fire, o_rsp.valid)
    `MQFB_ASSERT_NOW(a_empty_clean, i_clk, i_rst_n,
        o_rsp.valid && (o_rsp.payload.result_status == ST_EMPTY),
        (o_rsp.payload.taken_id == '0) && (o_rsp.payload.fill_after == '0))
    `MQFB_ASSERT_NOW(a_full_clean, i_clk, i_rst_n,
        o_rsp.valid && (o_rsp.payload.result_status == ST_FULL),
        (o_rsp.payload.taken_id == '0) && !o_rsp.payload.taken_urgent)

endmodule
